>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/lftiu_pkg.sv
// Types, constants and codes of the line/frame timer and interrupt unit.
package lftiu_pkg;

    // Timers and periods
    localparam int NUM_TIMERS      = 3;
    localparam int LINE_CYCLES_DEF = 256;
    localparam int FRAME_CYCLES    = 256 * 159;
    localparam int CNT_W           = 17;
    localparam int LINE_CYCLES_MAX = 4096;

    // Operation codes
    localparam logic [2:0] OP_ADVANCE = 3'd0;
    localparam logic [2:0] OP_SET     = 3'd1;
    localparam logic [2:0] OP_COMMIT  = 3'd2;
    localparam logic [2:0] OP_WRITE   = 3'd3;
    localparam logic [2:0] OP_RESET   = 3'd4;

    // Timer indexes
    localparam logic [1:0] TMR_LINE  = 2'd0;
    localparam logic [1:0] TMR_FRAME = 2'd1;
    localparam logic [1:0] TMR_DMA   = 2'd2;

    // Register selects
    localparam logic [2:0] REG_ENABLE  = 3'd0;
    localparam logic [2:0] REG_STATUS  = 3'd1;
    localparam logic [2:0] REG_RELOAD  = 3'd2;
    localparam logic [2:0] REG_LINECNT = 3'd3;
    localparam logic [2:0] REG_VBASE   = 3'd4;

    // Status / enable bits
    localparam int BIT_LINE  = 7;
    localparam int BIT_FRAME = 6;

    // Stream widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] cycles;
        logic        cpu_running;
        logic [1:0]  timer_index;
        logic [15:0] timer_value;
        logic [2:0]  reg_select;
        logic [7:0]  reg_value;
    } t_item;

    typedef struct packed {
        logic        audio_tick;
        logic        sound_dma;
        logic [1:0]  irq_count;
        logic        yield_cpu;
        logic        vector_valid;
        logic [10:0] vector_addr;
        logic [15:0] next_expiry;
    } t_result;

endpackage

>>> hdl/lftiu_in_stage.sv
// Input register stage: unpacks a stream transaction and holds it for the core.
module lftiu_in_stage (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [lftiu_pkg::S_TDATA_W-1:0]      i_data,
    input  logic [lftiu_pkg::S_TUSER_W-1:0]      i_user,
    output logic                                 o_valid,
    output lftiu_pkg::t_item                     o_item,
    input  logic                                 i_advance
);
    import lftiu_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    // Ready whenever the register is empty or drains this cycle
    assign o_ready = !r_valid || i_advance;

    // Unpack the transaction fields
    always_comb begin
        n_item.op          = i_user;
        n_item.cycles      = i_data[15:0];
        n_item.cpu_running = i_data[16];
        n_item.timer_index = i_data[18:17];
        n_item.timer_value = i_data[34:19];
        n_item.reg_select  = i_data[37:35];
        n_item.reg_value   = i_data[45:38];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> hdl/lftiu_core.sv
// Timer and interrupt state with the single-pass update for one item.
module lftiu_core #(
    parameter int LINE_CYCLES = lftiu_pkg::LINE_CYCLES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  lftiu_pkg::t_item     i_item,
    output lftiu_pkg::t_result   o_result
);
    import lftiu_pkg::*;

    localparam logic signed [CNT_W-1:0] LINE_RLD  = CNT_W'(LINE_CYCLES);
    localparam logic signed [CNT_W-1:0] FRAME_RLD = CNT_W'(FRAME_CYCLES);

    logic signed [CNT_W-1:0] r_cnt [NUM_TIMERS];
    logic signed [CNT_W-1:0] n_cnt [NUM_TIMERS];
    logic [15:0]             r_pend [NUM_TIMERS];
    logic [15:0]             n_pend [NUM_TIMERS];
    logic [7:0] r_en, n_en, r_stat, n_stat, r_rld, n_rld, r_lcnt, n_lcnt, r_vbase, n_vbase;

    logic signed [CNT_W-1:0] sub_cyc;
    logic signed [CNT_W-1:0] dec [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]   run;
    logic [NUM_TIMERS-1:0]   expire;
    logic [7:0]              lcnt_ld;
    logic [7:0]              lcnt_dec;
    logic                    line_step;
    logic                    line_irq;
    logic                    frame_irq;
    logic                    yield;
    logic [7:0]              pend_irq;
    logic [8:0]              vsum;
    logic [15:0]             nxt;

    assign sub_cyc = $signed({1'b0, i_item.cycles});

    // Running flags and decremented counts
    always_comb begin
        for (int k = 0; k < NUM_TIMERS; k++) begin
            run[k]    = !r_cnt[k][CNT_W-1] && (r_cnt[k] != '0);
            dec[k]    = r_cnt[k] - sub_cyc;
            expire[k] = run[k] && (dec[k][CNT_W-1] || (dec[k] == '0));
        end
    end

    // Line counter step on line expiry
    assign line_step = expire[0] && r_en[BIT_LINE] && (r_rld != 8'd0);
    assign lcnt_ld   = (r_lcnt == 8'd0) ? r_rld : r_lcnt;
    assign lcnt_dec  = lcnt_ld - 8'd1;
    assign line_irq  = line_step && (lcnt_dec == 8'd0);
    assign frame_irq = expire[1] && r_en[BIT_FRAME];

    // Next state for one item
    always_comb begin
        for (int k = 0; k < NUM_TIMERS; k++) begin
            n_cnt[k]  = r_cnt[k];
            n_pend[k] = r_pend[k];
        end
        n_en    = r_en;
        n_stat  = r_stat;
        n_rld   = r_rld;
        n_lcnt  = r_lcnt;
        n_vbase = r_vbase;
        yield   = 1'b0;
        case (i_item.op)
            OP_ADVANCE: begin
                for (int k = 0; k < NUM_TIMERS; k++) begin
                    if (run[k]) begin
                        n_cnt[k] = dec[k];
                    end
                end
                if (expire[0]) begin
                    n_cnt[0] = dec[0] + LINE_RLD;
                end
                if (expire[1]) begin
                    n_cnt[1] = dec[1] + FRAME_RLD;
                end
                if (line_step) begin
                    n_lcnt = lcnt_dec;
                end
                if (line_irq) begin
                    n_stat[BIT_LINE] = 1'b1;
                end
                if (frame_irq) begin
                    n_stat[BIT_FRAME] = 1'b1;
                end
            end
            OP_SET: begin
                if (i_item.timer_index inside {TMR_LINE, TMR_FRAME, TMR_DMA}) begin
                    if (i_item.cpu_running) begin
                        n_pend[i_item.timer_index] = i_item.timer_value;
                        yield = 1'b1;
                    end else begin
                        n_cnt[i_item.timer_index] = $signed({1'b0, i_item.timer_value});
                    end
                end
            end
            OP_COMMIT: begin
                for (int k = 0; k < NUM_TIMERS; k++) begin
                    if (r_pend[k] != 16'd0) begin
                        n_cnt[k]  = $signed({1'b0, r_pend[k]});
                        n_pend[k] = 16'd0;
                    end
                end
            end
            OP_WRITE: begin
                case (i_item.reg_select)
                    REG_ENABLE:  n_en    = i_item.reg_value;
                    REG_STATUS:  n_stat  = i_item.reg_value;
                    REG_RELOAD:  n_rld   = i_item.reg_value;
                    REG_LINECNT: n_lcnt  = i_item.reg_value;
                    REG_VBASE:   n_vbase = i_item.reg_value;
                    default: ;
                endcase
            end
            OP_RESET: begin
                n_cnt[0] = LINE_RLD;
                n_cnt[1] = FRAME_RLD;
                n_cnt[2] = '0;
                for (int k = 0; k < NUM_TIMERS; k++) begin
                    n_pend[k] = 16'd0;
                end
            end
            default: ;
        endcase
    end

    // Highest pending vector
    assign pend_irq = n_en & n_stat;
    always_comb begin
        vsum = 9'd0;
        if (pend_irq[BIT_LINE]) begin
            vsum = {1'b0, n_vbase} + 9'(BIT_LINE);
        end else if (pend_irq[BIT_FRAME]) begin
            vsum = {1'b0, n_vbase} + 9'(BIT_FRAME);
        end
    end

    // Smallest running count below the cycle limit
    always_comb begin
        nxt = i_item.cycles;
        for (int k = 0; k < NUM_TIMERS; k++) begin
            if (!n_cnt[k][CNT_W-1] && (n_cnt[k] != '0)
                && (n_cnt[k][15:0] < nxt) && !n_cnt[k][CNT_W-1]) begin
                nxt = n_cnt[k][15:0];
            end
        end
    end

    always_comb begin
        o_result.audio_tick   = (i_item.op == OP_ADVANCE) && expire[0];
        o_result.sound_dma    = (i_item.op == OP_ADVANCE) && expire[2];
        o_result.irq_count    = (i_item.op == OP_ADVANCE)
                                ? (2'(line_irq) + 2'(frame_irq)) : 2'd0;
        o_result.yield_cpu    = yield;
        o_result.vector_valid = pend_irq[BIT_LINE] || pend_irq[BIT_FRAME];
        o_result.vector_addr  = {vsum, 2'b00};
        o_result.next_expiry  = nxt;
    end

    // State registers, updated once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt[0] <= LINE_RLD;
            r_cnt[1] <= FRAME_RLD;
            r_cnt[2] <= '0;
            for (int k = 0; k < NUM_TIMERS; k++) begin
                r_pend[k] <= 16'd0;
            end
            r_en    <= 8'd0;
            r_stat  <= 8'd0;
            r_rld   <= 8'd0;
            r_lcnt  <= 8'd0;
            r_vbase <= 8'd0;
        end else if (i_fire) begin
            for (int k = 0; k < NUM_TIMERS; k++) begin
                r_cnt[k]  <= n_cnt[k];
                r_pend[k] <= n_pend[k];
            end
            r_en    <= n_en;
            r_stat  <= n_stat;
            r_rld   <= n_rld;
            r_lcnt  <= n_lcnt;
            r_vbase <= n_vbase;
        end
    end

endmodule

>>> hdl/lftiu_out_stage.sv
// Result register: packs a result and holds it until the sink takes it.
module lftiu_out_stage (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  lftiu_pkg::t_result                 i_result,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [lftiu_pkg::M_TDATA_W-1:0]    o_data
);
    import lftiu_pkg::*;

    logic                 r_valid;
    logic [M_TDATA_W-1:0] r_data;
    logic [M_TDATA_W-1:0] n_data;

    // Free when empty or the held transaction leaves this cycle
    assign o_ready = !r_valid || i_ready;

    assign n_data = {7'd0,
                     i_result.next_expiry,
                     i_result.vector_addr,
                     i_result.vector_valid,
                     i_result.yield_cpu,
                     i_result.irq_count,
                     i_result.sound_dma,
                     i_result.audio_tick};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hdl/line_frame_timer_interrupt_unit_top.sv
// Top level of the line/frame/sound-DMA timer and interrupt unit.
//
//  Channel | Direction | Ports                         | Payload
//  s_axis  | in        | tvalid/tready/tdata/tuser     | one timer/register item
//  m_axis  | out       | tvalid/tready/tdata           | one result per item
//
// One item per clock while the sink keeps taking results; an accepted item is held in
// the input register and moves into the result register when that register is free.
// Item work is a single combinational pass between the input register and the
// result register; the timer subtract/compare sets the critical path.
// Synchronous active-low reset returns the line and frame timers to their period
// values, clears the DMA timer and clears all interrupt registers and both stages.
// A stalled result holds in the result register; the input side keeps taking
// items while its own register is empty or the result register drains or is empty.
module line_frame_timer_interrupt_unit_top #(
    parameter int LINE_CYCLES = lftiu_pkg::LINE_CYCLES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // cycles[15:0], cpu_running[16], timer_index[18:17], timer_value[34:19],
    // reg_select[37:35], reg_value[45:38], zero fill [47:46]
    input  logic [lftiu_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // op[2:0]
    input  logic [lftiu_pkg::S_TUSER_W-1:0]    i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // audio_tick[0], sound_dma[1], irq_count[3:2], yield_cpu[4],
    // vector_valid[5], vector_addr[16:6], next_expiry[32:17], zero fill [39:33]
    output logic [lftiu_pkg::M_TDATA_W-1:0]    o_m_axis_tdata
);
    import lftiu_pkg::*;

    logic    in_valid;
    t_item   in_item;
    logic    out_free;
    logic    fire;
    t_result result;

    // An item moves into the result register when that register is free
    assign fire = in_valid && out_free;

    lftiu_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_data    (i_s_axis_tdata),
        .i_user    (i_s_axis_tuser),
        .o_valid   (in_valid),
        .o_item    (in_item),
        .i_advance (fire)
    );

    lftiu_core #(
        .LINE_CYCLES (LINE_CYCLES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (in_item),
        .o_result (result)
    );

    lftiu_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_valid),
        .o_ready  (out_free),
        .i_result (result),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_data   (o_m_axis_tdata)
    );

endmodule

>>> hdl/lftiu_checker.sv
// Port-level checker for the timer and interrupt unit, bound to the top level.
`include "assert_macros.svh"

module lftiu_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_axis_tvalid,
    input logic                               o_s_axis_tready,
    input logic [lftiu_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    input logic [lftiu_pkg::S_TUSER_W-1:0]    i_s_axis_tuser,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [lftiu_pkg::M_TDATA_W-1:0]    o_m_axis_tdata
);

    // A result waiting on the sink stays put
    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "result changed while stalled")

    // Reset empties the result register
    `ASSERT_CLK(a_rst_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")

    // At most two requests (line and frame) per item
    `ASSERT_CLK_RST(a_irq_cnt, i_clk, i_rst_n, o_m_axis_tvalid |-> o_m_axis_tdata[3:2] != 2'b11, "irq_count out of range")

    // No pending vector means a zero address
    `ASSERT_CLK_RST(a_vec_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tdata[5] |-> o_m_axis_tdata[16:6] == 11'd0, "vector address without vector")

    // A vector address is word aligned and at least the frame slot
    `ASSERT_CLK_RST(a_vec_align, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[5] |-> o_m_axis_tdata[7:6] == 2'b00 && o_m_axis_tdata[16:6] >= 11'd24, "vector address malformed")

endmodule

bind line_frame_timer_interrupt_unit_top lftiu_checker u_lftiu_checker (.*);
